@@ sv/c2d_pkg.sv @@
package c2d_pkg;

   // Fixed geometry of the filter
   localparam int KERNEL     = 7;
   localparam int HIST       = KERNEL - 1;
   localparam int TAPS       = KERNEL * KERNEL;
   localparam int DATA_W     = 32;
   localparam int REG_W      = 7;
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_ROWS   = 64;
   localparam int FIFO_DEPTH = 8;

   // Item function codes
   localparam logic FUNC_COEFF  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Register indexes
   localparam logic CSR_OUT_WIDTH = 1'b0;
   localparam logic CSR_OUT_ROWS  = 1'b1;

   typedef struct packed {
      logic               func;
      logic [5:0]         coeff_index;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic               last;
   } rsp_type;

   typedef logic [TAPS-1:0][DATA_W-1:0] tap_vec_type;
   typedef logic [HIST-1:0][DATA_W-1:0] line_word_type;

   // Front to MAC handoff
   typedef struct packed {
      logic go;
      logic last;
   } mac_ctl_type;

endpackage

@@ sv/conv2d_7x7_valid_int32.sv @@
// A result passes stage 1, the MAC control register, the product, row-sum and sum registers, then the result queue.
// Throughput: one item per cycle while req_full is low; the 49 multipliers and the row adders are pipelined.
// req_full rises when 8 results are waiting or in flight (credit for the result queue).
// Reset: synchronous, active high; clears position, credits and valids, sets both
// registers to 64. Coefficients and line store hold no reset value.
module conv2d_7x7_valid_int32 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  c2d_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output c2d_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [6:0]       csr_wdata
);
   import c2d_pkg::*;

   mac_ctl_type mac_ctl;
   tap_vec_type window, coeffs;
   logic        res_push;
   rsp_type     res_data;
   logic        pop_done;

   assign pop_done = rsp_pop && !rsp_empty;

   c2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pop_done  (pop_done),
      .mac_ctl   (mac_ctl),
      .window    (window),
      .coeffs    (coeffs)
   );

   c2d_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_ctl  (mac_ctl),
      .window   (window),
      .coeffs   (coeffs),
      .res_push (res_push),
      .res_data (res_data)
   );

   c2d_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

@@ sv/c2d_fifo.sv @@
module c2d_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  c2d_pkg::rsp_type wdata,
   input  logic             pop,
   output c2d_pkg::rsp_type rdata,
   output logic             empty
);
   import c2d_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rsp_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   // Pointer and fill count update; space is guaranteed by the front's credit count
   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);

endmodule

@@ sv/c2d_mac.sv @@
module c2d_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  c2d_pkg::mac_ctl_type mac_ctl,
   input  c2d_pkg::tap_vec_type window,
   input  c2d_pkg::tap_vec_type coeffs,
   output logic                 res_push,
   output c2d_pkg::rsp_type     res_data
);
   import c2d_pkg::*;

   tap_vec_type                    prod_ff;
   logic [KERNEL-1:0][DATA_W-1:0]  part_ff, part_in;
   logic [DATA_W-1:0]              sum_ff, sum_in;
   logic                           va_ff, vb_ff, vc_ff;
   logic                           la_ff, lb_ff, lc_ff;

   // Stage A: one product per tap, low 32 bits
   always_ff @(posedge clock) begin
      if (mac_ctl.go) begin
         for (int i = 0; i < TAPS; i++) begin
            prod_ff[i] <= coeffs[i] * window[i];
         end
      end
   end

   // Stage B: one partial sum per kernel row
   always_comb begin
      for (int r = 0; r < KERNEL; r++) begin
         part_in[r] = '0;
         for (int c = 0; c < KERNEL; c++) begin
            part_in[r] = part_in[r] + prod_ff[r*KERNEL + c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (va_ff) begin
         part_ff <= part_in;
      end
   end

   // Stage C: final wrapped sum
   always_comb begin
      sum_in = '0;
      for (int r = 0; r < KERNEL; r++) begin
         sum_in = sum_in + part_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (vb_ff) begin
         sum_ff <= sum_in;
      end
   end

   // Valid and last travel alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= mac_ctl.go;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      la_ff <= mac_ctl.last;
      lb_ff <= la_ff;
      lc_ff <= lb_ff;
   end

   assign res_push           = vc_ff;
   assign res_data.out_value = sum_ff;
   assign res_data.last      = lc_ff;

endmodule

@@ sv/c2d_front.sv @@
module c2d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  c2d_pkg::req_type     req_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [6:0]           csr_wdata,
   input  logic                 pop_done,
   output c2d_pkg::mac_ctl_type mac_ctl,
   output c2d_pkg::tap_vec_type window,
   output c2d_pkg::tap_vec_type coeffs
);
   import c2d_pkg::*;

   localparam int LINE_COLS = MAX_WIDTH + HIST;
   localparam int ADDR_W    = $clog2(LINE_COLS);
   localparam int RSV_W     = $clog2(FIFO_DEPTH + 1);

   logic [REG_W-1:0]  out_width_ff, out_width_in;
   logic [REG_W-1:0]  out_rows_ff, out_rows_in;
   logic [REG_W-1:0]  in_col_ff, in_col_in;
   logic [REG_W-1:0]  in_row_ff, in_row_in;
   logic [RSV_W-1:0]  rsv_ff, rsv_in;

   logic [REG_W-1:0]  width_c, rows_c, col_n, row_n;
   logic [REG_W:0]    width_in, rows_in;
   logic              col_wrap, row_wrap, emit0, last0;
   logic              accept, is_sample, csr_wr;
   logic [ADDR_W-1:0] addr0;

   line_word_type     line_mem [LINE_COLS];
   line_word_type     line_rd_ff;
   line_word_type     line_wr;

   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_emit_ff, s1_last_ff;
   logic              s1_sample, s1_coeff;

   logic [KERNEL-1:0][DATA_W-1:0] column;
   tap_vec_type       win_ff, win_in;
   tap_vec_type       coeff_ff;
   mac_ctl_type       mac_ctl_ff, mac_ctl_in;

   // Geometry and current image position
   always_comb begin
      if (out_width_ff == '0) begin
         width_c = REG_W'(1);
      end else if (32'(out_width_ff) > MAX_WIDTH) begin
         width_c = REG_W'(MAX_WIDTH);
      end else begin
         width_c = out_width_ff;
      end
      if (out_rows_ff == '0) begin
         rows_c = REG_W'(1);
      end else if (32'(out_rows_ff) > MAX_ROWS) begin
         rows_c = REG_W'(MAX_ROWS);
      end else begin
         rows_c = out_rows_ff;
      end
      width_in = {1'b0, width_c} + (REG_W+1)'(HIST);
      rows_in  = {1'b0, rows_c} + (REG_W+1)'(HIST);

      col_n = in_col_ff;
      if (({1'b0, in_col_ff} >= width_in) || (32'(in_col_ff) >= LINE_COLS)) begin
         col_n = '0;
      end
      row_n = in_row_ff;
      if ({1'b0, in_row_ff} >= rows_in) begin
         row_n = '0;
      end

      col_wrap = ({1'b0, col_n} + (REG_W+1)'(1)) >= width_in;
      row_wrap = ({1'b0, row_n} + (REG_W+1)'(1)) >= rows_in;
      emit0    = (row_n >= REG_W'(HIST)) && (col_n >= REG_W'(HIST));
      last0    = col_wrap && row_wrap;
      addr0    = ADDR_W'(col_n);
   end

   // Input transfer, register writes and credit count
   always_comb begin
      accept    = req_push && !req_full;
      is_sample = (req_data.func == FUNC_SAMPLE);
      csr_wr    = csr_valid && csr_ready;

      out_width_in = out_width_ff;
      out_rows_in  = out_rows_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;

      if (csr_wr) begin
         unique case (csr_index)
            CSR_OUT_WIDTH: out_width_in = csr_wdata;
            CSR_OUT_ROWS:  out_rows_in  = csr_wdata;
            default:       out_width_in = out_width_ff;
         endcase
         in_col_in = '0;
         in_row_in = '0;
      end else if (accept && is_sample) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = row_wrap ? '0 : row_n + REG_W'(1);
         end else begin
            in_col_in = col_n + REG_W'(1);
            in_row_in = row_n;
         end
      end

      rsv_in = rsv_ff + RSV_W'(accept && is_sample && emit0) - RSV_W'(pop_done);
   end

   assign req_full  = (32'(rsv_ff) >= FIFO_DEPTH);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff <= REG_W'(64);
         out_rows_ff  <= REG_W'(64);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         rsv_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         mac_ctl_ff   <= '0;
      end else begin
         out_width_ff <= out_width_in;
         out_rows_ff  <= out_rows_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         rsv_ff       <= rsv_in;
         s1_valid_ff  <= accept;
         mac_ctl_ff   <= mac_ctl_in;
      end
   end

   // Stage 1 payload and line store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_data;
         s1_addr_ff <= addr0;
         s1_emit_ff <= emit0;
         s1_last_ff <= last0;
      end
      if (accept && is_sample) begin
         line_rd_ff <= line_mem[addr0];
      end
   end

   // Stage 1: build the new column, shift the window, update the line store
   always_comb begin
      s1_sample = s1_valid_ff && (s1_req_ff.func == FUNC_SAMPLE);
      s1_coeff  = s1_valid_ff && (s1_req_ff.func == FUNC_COEFF)
                  && (32'(s1_req_ff.coeff_index) < TAPS);
      for (int r = 0; r < HIST; r++) begin
         column[r] = line_rd_ff[r];
      end
      column[HIST] = s1_req_ff.sample_value;
      for (int r = 0; r < HIST; r++) begin
         line_wr[r] = column[r+1];
      end
      for (int r = 0; r < KERNEL; r++) begin
         for (int c = 0; c < KERNEL - 1; c++) begin
            win_in[r*KERNEL + c] = win_ff[r*KERNEL + c + 1];
         end
         win_in[r*KERNEL + KERNEL - 1] = column[r];
      end
      mac_ctl_in.go   = s1_sample && s1_emit_ff;
      mac_ctl_in.last = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_sample) begin
         line_mem[s1_addr_ff] <= line_wr;
         win_ff               <= win_in;
      end
      if (s1_coeff) begin
         coeff_ff[s1_req_ff.coeff_index] <= s1_req_ff.sample_value;
      end
   end

   assign mac_ctl = mac_ctl_ff;
   assign window  = win_ff;
   assign coeffs  = coeff_ff;

endmodule
